// ----- src/mhk_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhk_pkg: shared definitions for the key hash block
// Mix constants, operand select codes and the control bundle that the
// sequencer hands to the datapath.
// ----------------------------------------------------------------------------
package mhk_pkg;

	localparam logic [31:0] MixMul    = 32'h5bd1_e995;
	localparam int          WordShift = 24;
	localparam int          FinShiftA = 13;
	localparam int          FinShiftB = 15;
	localparam logic [31:0] SeedReset = 32'd97;

	// operand select codes for the shared multiplier
	localparam logic [2:0] OP_WORD = 3'd0;
	localparam logic [2:0] OP_KMIX = 3'd1;
	localparam logic [2:0] OP_HASH = 3'd2;
	localparam logic [2:0] OP_TAIL = 3'd3;
	localparam logic [2:0] OP_FIN  = 3'd4;

	typedef struct packed {
		logic       busy;
		logic [2:0] op_sel;
		logic       mul_en;
		logic       k_load;
		logic       k_clear;
		logic       h_fold;
		logic       out_load;
	} ctl_t;

	// byte mask for a short word of one to three bytes
	function automatic logic [31:0] tail_mask(input logic [1:0] nbytes);
		logic [31:0] m;
		case (nbytes)
			2'd1: m = 32'h0000_00ff;
			2'd2: m = 32'h0000_ffff;
			default: m = 32'h00ff_ffff;
		endcase
		return m;
	endfunction

endpackage

// ----- src/mhk_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhk_mul: shared mix multiplier
// Multiplies the selected operand by the mix constant modulo 2^32 and
// registers the product when enabled.
// ----------------------------------------------------------------------------
module mhk_mul (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] operand,
	output logic [31:0] product_q
);
	import mhk_pkg::*;

	logic [31:0] full;

	// low word of the product is all the hash needs
	assign full = operand * MixMul;

	always_ff @(posedge clk) begin
		if (en) begin
			product_q <= full;
		end
	end

endmodule

// ----- src/mhk_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhk_ctrl: word sequencer
// Steps one key word through the full mix or the tail path (none if empty)
// on the shared multiplier, then through finalization if it closes the key.
// ----------------------------------------------------------------------------
module mhk_ctrl (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic         nb_full,
	input  logic         nb_zero,
	input  logic         last,
	input  logic         out_free,
	output mhk_pkg::ctl_t ctl
);
	import mhk_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_K1   = 3'd1;
	localparam logic [2:0] ST_K2   = 3'd2;
	localparam logic [2:0] ST_H    = 3'd3;
	localparam logic [2:0] ST_TAIL = 3'd4;
	localparam logic [2:0] ST_FOLD = 3'd5;
	localparam logic [2:0] ST_FIN1 = 3'd6;
	localparam logic [2:0] ST_FIN2 = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       last_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (nb_full) begin
						state_d = ST_K1;
					end else if (!nb_zero) begin
						state_d = ST_TAIL;
					end else if (last) begin
						state_d = ST_FIN1;
					end
				end
			end
			ST_K1:   state_d = ST_K2;
			ST_K2:   state_d = ST_H;
			ST_H:    state_d = ST_FOLD;
			ST_TAIL: state_d = ST_FOLD;
			ST_FOLD: state_d = last_q ? ST_FIN1 : ST_IDLE;
			ST_FIN1: state_d = ST_FIN2;
			ST_FIN2: state_d = out_free ? ST_IDLE : ST_FIN2;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				last_q <= last;
			end
		end
	end

	// datapath controls per state
	always_comb begin
		ctl          = '0;
		ctl.busy     = (state_q != ST_IDLE);
		ctl.op_sel   = OP_WORD;
		case (state_q)
			ST_K1: begin
				ctl.op_sel = OP_WORD;
				ctl.mul_en = 1'b1;
			end
			ST_K2: begin
				ctl.op_sel = OP_KMIX;
				ctl.mul_en = 1'b1;
			end
			ST_H: begin
				ctl.op_sel = OP_HASH;
				ctl.mul_en = 1'b1;
				ctl.k_load = 1'b1;
			end
			ST_TAIL: begin
				ctl.op_sel  = OP_TAIL;
				ctl.mul_en  = 1'b1;
				ctl.k_clear = 1'b1;
			end
			ST_FOLD: begin
				ctl.h_fold = 1'b1;
			end
			ST_FIN1: begin
				ctl.op_sel = OP_FIN;
				ctl.mul_en = 1'b1;
			end
			ST_FIN2: begin
				ctl.out_load = out_free;
			end
			default: begin
				ctl.op_sel = OP_WORD;
			end
		endcase
	end

endmodule

// ----- src/murmur2_key_hash.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur2_key_hash: 32-bit MurmurHash2 of a streamed key
// Hashes a key given as little-endian 32-bit words with one shared
// constant multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one key word per beat (in_valid / in_stall).
//   is_first loads the running hash with hash_seed ^ key_length; is_last
//   makes the block finalize and deliver one hash on the output channel
//   (out_valid / out_stall). hash_seed is written through cfg_wr_en and
//   cfg_wr_data by the user while the block is idle (not enforced).
//   Each word runs on the single multiplier that does every multiply: a full
//   word steps through the word, key mix and hash multiplies and a fold, a
//   short word through the tail multiply and a fold, with the input stalled;
//   an empty word that is not last is only taken. A last word adds a final
//   multiply and an output step that waits until the output register frees.
//   The output register frees the input side: a new word is taken while a
//   hash waits. If a second hash finishes while the first is still stalled,
//   the sequencer waits in its final step until the output register frees.
//   Reset sets hash_seed to 97, clears the running hash and empties the
//   output register.
// ----------------------------------------------------------------------------
module murmur2_key_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] key_word,
	input  logic [2:0]  word_bytes,
	input  logic        is_first,
	input  logic        is_last,
	input  logic [30:0] key_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] hash_value
);
	import mhk_pkg::*;

	ctl_t        ctl;
	logic        in_beat;
	logic        out_free;
	logic [31:0] seed_q;
	logic [31:0] h_q;
	logic [31:0] k_q;
	logic [31:0] word_q;
	logic [1:0]  nbytes_q;
	logic [31:0] p_q;
	logic [31:0] operand;
	logic        out_valid_q;
	logic [31:0] hash_q;
	logic [31:0] fin_value;

	assign in_stall  = ctl.busy;
	assign in_beat   = in_valid && !ctl.busy;
	assign out_free  = !out_valid_q || !out_stall;

	// sequencer
	mhk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_beat),
		.nb_full  (word_bytes[2]),
		.nb_zero  (word_bytes == 3'd0),
		.last     (is_last),
		.out_free (out_free),
		.ctl      (ctl)
	);

	// operand select for the shared multiplier
	always_comb begin
		case (ctl.op_sel)
			OP_WORD: operand = word_q;
			OP_KMIX: operand = p_q ^ (p_q >> WordShift);
			OP_HASH: operand = h_q;
			OP_TAIL: operand = h_q ^ (word_q & tail_mask(nbytes_q));
			OP_FIN:  operand = h_q ^ (h_q >> FinShiftA);
			default: operand = '0;
		endcase
	end

	mhk_mul u_mul (
		.clk       (clk),
		.en        (ctl.mul_en),
		.operand   (operand),
		.product_q (p_q)
	);

	// seed register and running hash
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SeedReset;
			h_q    <= '0;
		end else begin
			if (cfg_wr_en) begin
				seed_q <= cfg_wr_data;
			end
			if (in_beat && is_first) begin
				h_q <= seed_q ^ {1'b0, key_length};
			end else if (ctl.h_fold) begin
				h_q <= p_q ^ k_q;
			end
		end
	end

	// word capture and mixed key hold
	always_ff @(posedge clk) begin
		if (in_beat) begin
			word_q   <= key_word;
			nbytes_q <= word_bytes[1:0];
		end
		if (ctl.k_load) begin
			k_q <= p_q;
		end else if (ctl.k_clear) begin
			k_q <= '0;
		end
	end

	// output register
	assign fin_value = p_q ^ (p_q >> FinShiftB);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			hash_q <= fin_value;
		end
	end

	assign out_valid  = out_valid_q;
	assign hash_value = hash_q;

	// a finished hash never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> (!out_valid_q || !out_stall))
		else $error("hash loaded over a stalled result");

	// a fold always follows a multiply
	a_fold_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.h_fold |-> $past(ctl.mul_en))
		else $error("fold without a preceding multiply");

	// register updates are exclusive steps
	a_onehot_steps: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.k_load, ctl.k_clear, ctl.h_fold, ctl.out_load}))
		else $error("more than one datapath step at once");

	// the running hash holds while finalization runs
	a_hash_holds: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> $stable(h_q))
		else $error("running hash changed during finalization");

endmodule
